// ----- hdl/ufr_pkg.sv -----
// Shared constants for the frame receiver: field widths, phase, status, opcode and register codes.
package ufr_pkg;

	// Number of big-endian length bytes after the header (1 or 2).
	localparam int LENGTH_BYTES = 2;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int STAT_W  = 2;
	localparam int PHASE_W = 2;
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 16;

	// Receiver phases.
	localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_PAY  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_SUM  = 2'd3;

	// Frame status codes.
	localparam logic [STAT_W-1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [STAT_W-1:0] ST_COMPLETE   = 2'd1;
	localparam logic [STAT_W-1:0] ST_LEN_ERR    = 2'd2;
	localparam logic [STAT_W-1:0] ST_SUM_ERR    = 2'd3;

	// Input opcodes.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_HEADER_BYTE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_EN    = 2'd2;

	// Reset value of the maximum payload length register.
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd256;

	// One result transaction.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  payload_index;
	} result_t;

endpackage

// ----- hdl/uart_frame_receiver.sv -----
// Header / length / payload / sum-8 frame receiver with a two-stage valid/stall pipeline.
// A transaction accepted into stage 1 has its result registered in stage 2 once the result
// register can load, and the sink takes it from there.
// Throughput: one transaction per cycle while the sink does not stall; the frame state step is
// combinational logic between the input and result registers, and it closes its own loop.
// Reset (arst_n low, asynchronous): both pipeline stages empty, receiver hunting for a header,
// status incomplete, counters and sum cleared, registers at header 0, maximum 256, check off.
module uart_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [ufr_pkg::BYTE_W-1:0]    rx_byte,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ufr_pkg::STAT_W-1:0]    status,
	output logic                          payload_valid,
	output logic [ufr_pkg::BYTE_W-1:0]    payload_byte,
	output logic [ufr_pkg::LEN_W-1:0]     payload_index,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [ufr_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ufr_pkg::REG_DATA_W-1:0] cfg_data
);
	import ufr_pkg::*;

	// Configuration registers.
	logic [BYTE_W-1:0] header_byte_q;
	logic [LEN_W-1:0]  max_length_q;
	logic              check_en_q;

	// Frame state.
	logic [PHASE_W-1:0] phase_q;
	logic [STAT_W-1:0]  frame_status_q;
	logic [LEN_W-1:0]   byte_counter_q;
	logic [LEN_W-1:0]   frame_length_q;
	logic [BYTE_W-1:0]  running_sum_q;

	// Stage 1 holds the accepted transaction, stage 2 the finished result.
	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           result_s2;

	// Next-state and result logic.
	logic [PHASE_W-1:0] phase_d;
	logic [STAT_W-1:0]  frame_status_d;
	logic [LEN_W-1:0]   byte_counter_d;
	logic [LEN_W-1:0]   frame_length_d;
	logic [BYTE_W-1:0]  running_sum_d;
	logic [LEN_W-1:0]   counter_inc;
	logic [LEN_W-1:0]   length_shift;
	result_t            result_d;

	logic out_load;
	logic s1_move;

	// The result register can take a new value when it is empty or being drained.
	assign out_load = !valid_s2 || !out_stall;
	assign s1_move  = valid_s1 && out_load;
	// Stage 1 is full and cannot advance, so a new transaction must wait.
	assign in_stall = valid_s1 && !out_load;

	assign counter_inc  = byte_counter_q + LEN_W'(1);
	assign length_shift = {frame_length_q[LEN_W-BYTE_W-1:0], byte_s1};

	// Configuration writes; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= '0;
			max_length_q  <= MAX_LENGTH_RESET;
			check_en_q    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEADER_BYTE) header_byte_q <= cfg_data[BYTE_W-1:0];
			if (cfg_index == REG_MAX_LENGTH)  max_length_q  <= cfg_data[LEN_W-1:0];
			if (cfg_index == REG_CHECK_EN)    check_en_q    <= cfg_data[0];
		end
	end

	// One state step per transaction in stage 1. A restart clears the frame state; a completed
	// frame holds until restart; otherwise the phase decides what the byte means.
	always_comb begin
		phase_d        = phase_q;
		frame_status_d = frame_status_q;
		byte_counter_d = byte_counter_q;
		frame_length_d = frame_length_q;
		running_sum_d  = running_sum_q;
		result_d.payload_valid = 1'b0;
		result_d.payload_byte  = '0;
		result_d.payload_index = '0;
		if (op_s1 == OP_RESTART) begin
			phase_d        = PH_HUNT;
			frame_status_d = ST_INCOMPLETE;
			byte_counter_d = '0;
			frame_length_d = '0;
			running_sum_d  = '0;
		end else if (frame_status_q != ST_COMPLETE) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == header_byte_q) begin
						phase_d        = PH_LEN;
						byte_counter_d = '0;
						frame_length_d = '0;
						running_sum_d  = byte_s1;
					end
				end
				PH_LEN: begin
					frame_length_d = length_shift;
					byte_counter_d = counter_inc;
					running_sum_d  = running_sum_q + byte_s1;
					if (counter_inc >= LEN_W'(LENGTH_BYTES)) begin
						byte_counter_d = '0;
						if (length_shift > max_length_q) begin
							frame_status_d = ST_LEN_ERR;
							phase_d        = PH_HUNT;
						end else if (length_shift == '0) begin
							phase_d = PH_SUM;
						end else begin
							phase_d = PH_PAY;
						end
					end
				end
				PH_PAY: begin
					result_d.payload_valid = 1'b1;
					result_d.payload_byte  = byte_s1;
					result_d.payload_index = byte_counter_q;
					byte_counter_d = counter_inc;
					running_sum_d  = running_sum_q + byte_s1;
					if (counter_inc == frame_length_q) begin
						phase_d        = PH_SUM;
						byte_counter_d = '0;
					end
				end
				PH_SUM: begin
					if (check_en_q && byte_s1 != running_sum_q) frame_status_d = ST_SUM_ERR;
					else frame_status_d = ST_COMPLETE;
					phase_d = PH_HUNT;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
		result_d.status = frame_status_d;
	end

	// Stage 1 valid and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			phase_q        <= PH_HUNT;
			frame_status_q <= ST_INCOMPLETE;
			byte_counter_q <= '0;
			frame_length_q <= '0;
			running_sum_q  <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (s1_move) begin
				phase_q        <= phase_d;
				frame_status_q <= frame_status_d;
				byte_counter_q <= byte_counter_d;
				frame_length_q <= frame_length_d;
				running_sum_q  <= running_sum_d;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) result_s2 <= result_d;
	end

	assign out_valid     = valid_s2;
	assign status        = result_s2.status;
	assign payload_valid = result_s2.payload_valid;
	assign payload_byte  = result_s2.payload_byte;
	assign payload_index = result_s2.payload_index;

	// A payload byte is only ever reported while the frame is still open.
	a_pay_not_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> status != ST_COMPLETE)
		else $error("payload byte reported with a completed frame status");

	// Inside the payload the index always stays below the frame length.
	a_pay_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> byte_counter_q < frame_length_q)
		else $error("payload counter reached the frame length");

	// Non-payload results carry zero byte and index.
	a_non_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
		else $error("non-payload result carries payload data");

	// The input is held back only while both stages are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

endmodule

// ----- tb/sv/tb_uart_frame_receiver.sv -----
// Self-checking testbench for the header/length/payload/sum-8 frame receiver.
module tb_uart_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import ufr_pkg::*;

	// Tracks the receiver's frame state byte by byte and holds the result
	// that each accepted transaction should produce, oldest first.
	class frame_checker;
		logic [BYTE_W-1:0]  header_byte;
		logic [LEN_W-1:0]   max_length;
		logic               check_en;
		logic [PHASE_W-1:0] rx_phase;
		logic [STAT_W-1:0]  frame_status;
		logic [LEN_W-1:0]   byte_count;
		logic [LEN_W-1:0]   frame_length;
		logic [BYTE_W-1:0]  running_sum;
		result_t            expected_results[$];
		int                 errors;

		function new();
			header_byte = '0;
			max_length = MAX_LENGTH_RESET;
			check_en = 1'b0;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			rx_phase = PH_HUNT;
			frame_status = ST_INCOMPLETE;
			byte_count = '0;
			frame_length = '0;
			running_sum = '0;
		endfunction

		// Register writes keep only the bits that the register holds.
		function void write_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
			case (idx)
			REG_HEADER_BYTE: header_byte = data[BYTE_W-1:0];
			REG_MAX_LENGTH:  max_length = data[LEN_W-1:0];
			REG_CHECK_EN:    check_en = data[0];
			default: ;
			endcase
		endfunction

		// Steps the frame state by one transaction and queues the result it gives.
		function void advance_frame(logic o, logic [BYTE_W-1:0] b);
			result_t r;
			r = '0;
			if (o == OP_RESTART) begin
				clear_frame();
			end else if (frame_status != ST_COMPLETE) begin
				case (rx_phase)
				PH_HUNT: begin
					if (b == header_byte) begin
						rx_phase = PH_LEN;
						byte_count = '0;
						frame_length = '0;
						running_sum = b;
					end
				end
				PH_LEN: begin
					frame_length = {frame_length[LEN_W-BYTE_W-1:0], b};
					byte_count = byte_count + 1'b1;
					if (byte_count >= LENGTH_BYTES) begin
						byte_count = '0;
						if (frame_length > max_length) begin
							frame_status = ST_LEN_ERR;
							rx_phase = PH_HUNT;
						end else if (frame_length == '0) begin
							rx_phase = PH_SUM;
						end else begin
							rx_phase = PH_PAY;
						end
					end
					running_sum = running_sum + b;
				end
				PH_PAY: begin
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = byte_count;
					byte_count = byte_count + 1'b1;
					if (byte_count == frame_length) begin
						rx_phase = PH_SUM;
						byte_count = '0;
					end
					running_sum = running_sum + b;
				end
				default: begin
					if (check_en && b != running_sum)
						frame_status = ST_SUM_ERR;
					else
						frame_status = ST_COMPLETE;
					rx_phase = PH_HUNT;
				end
				endcase
			end
			r.status = frame_status;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
					got.status, got.payload_valid, got.payload_byte, got.payload_index);
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("payload_valid", want.payload_valid, got.payload_valid);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("payload_index", want.payload_index, got.payload_index);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [BYTE_W-1:0]     rx_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [STAT_W-1:0]     status;
	logic                  payload_valid;
	logic [BYTE_W-1:0]     payload_byte;
	logic [LEN_W-1:0]      payload_index;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [REG_DATA_W-1:0] cfg_data;

	frame_checker chk;
	int           items_sent;
	// Idle controls: the sender inserts gaps, the sink raises stall in bursts.
	// The tail of the run turns both off and keeps them off.
	bit           src_idle_en;
	bit           sink_stall_en;
	bit           quiet_tail;

	uart_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both channels are observed at the rising edge, where the values seen are the ones
	// that were settled before the edge. An input transaction feeds the tracker, and an
	// output transaction is checked against the oldest queued expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				chk.advance_frame(op, rx_byte);
			if (out_valid && !out_stall)
				chk.check_result({status, payload_valid, payload_byte, payload_index});
		end
	end

	// The sink stalls in bursts of random length whenever it is allowed to.
	always begin
		@(negedge clk);
		if (sink_stall_en && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 18)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	// Presents one transaction and returns at the falling edge after it is taken.
	// Valid stays high between back-to-back transactions; it only drops for a gap.
	task automatic send_item(input logic o, input logic [BYTE_W-1:0] b);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends the header and the big-endian length, returning the sum so far.
	task automatic send_prefix(input int len, output logic [BYTE_W-1:0] sum);
		logic [BYTE_W-1:0] lb;
		sum = chk.header_byte;
		send_item(OP_BYTE, chk.header_byte);
		for (int i = LENGTH_BYTES - 1; i >= 0; i--) begin
			lb = BYTE_W'(len >> (BYTE_W * i));
			send_item(OP_BYTE, lb);
			sum = sum + lb;
		end
	endtask

	// A whole frame with random payload; a corrupt frame flips one bit of the sum byte.
	task automatic send_frame(input int len, input bit corrupt);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] pb;
		send_prefix(len, sum);
		repeat (len) begin
			pb = BYTE_W'($urandom);
			send_item(OP_BYTE, pb);
			sum = sum + pb;
		end
		if (corrupt)
			sum = sum ^ (8'h01 << $urandom_range(0, 7));
		send_item(OP_BYTE, sum);
	endtask

	// Every transaction gives exactly one result, so an empty queue means the pipeline is empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (chk.expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		chk.write_register(idx, data);
	endtask

	// Unused upper bits of the narrow registers carry random junk that must be dropped.
	task automatic program_registers(input logic [BYTE_W-1:0] hdr, input logic [LEN_W-1:0] max_len,
			input logic check);
		wait_idle();
		write_reg(REG_HEADER_BYTE, {8'($urandom), hdr});
		write_reg(REG_MAX_LENGTH, max_len);
		write_reg(REG_CHECK_EN, {15'($urandom), check});
	endtask

	// Random traffic that is mostly well-formed frames with random content, plus
	// over-long lengths, line noise, restarts and frames cut short by a restart.
	task automatic run_random(input int quota);
		int                stop_at;
		int                pick;
		int                len;
		int                cap;
		logic [BYTE_W-1:0] sum;
		stop_at = items_sent + quota;
		if (!quiet_tail) begin
			src_idle_en = 1'($urandom_range(0, 1));
			sink_stall_en = 1'($urandom_range(0, 1));
		end
		while (items_sent < stop_at) begin
			if (!quiet_tail && $urandom_range(0, 19) == 0)
				src_idle_en = !src_idle_en;
			if (!quiet_tail && $urandom_range(0, 19) == 0)
				sink_stall_en = !sink_stall_en;
			pick = $urandom_range(0, 99);
			cap = (chk.max_length < 12) ? chk.max_length : 12;
			if (pick < 60) begin
				len = $urandom_range(0, cap);
				// Now and then a frame right at the maximum, when that is short enough.
				if ($urandom_range(0, 7) == 0 && chk.max_length <= 40)
					len = chk.max_length;
				send_frame(len, $urandom_range(0, 4) == 0);
				// A completed frame latches, so most frames are followed by a restart.
				if ($urandom_range(0, 9) != 0)
					send_item(OP_RESTART, BYTE_W'($urandom));
			end else if (pick < 70 && chk.max_length != 16'hFFFF) begin
				len = chk.max_length + 1 + $urandom_range(0, 30);
				if (len > 65535 || $urandom_range(0, 9) == 0)
					len = 65535;
				send_prefix(len, sum);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 4)) send_item(OP_BYTE, BYTE_W'($urandom));
			end else if (pick < 88) begin
				send_item(OP_RESTART, BYTE_W'($urandom));
			end else begin
				// A frame abandoned part way; with a large maximum the length can be huge.
				len = (chk.max_length == 0) ? 0 : $urandom_range(1, chk.max_length);
				send_prefix(len, sum);
				repeat ($urandom_range(0, (len < 6) ? len : 6))
					send_item(OP_BYTE, BYTE_W'($urandom));
				send_item(OP_RESTART, BYTE_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] sum;

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_BYTE;
		rx_byte = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEADER_BYTE;
		cfg_data = '0;
		src_idle_en = 1'b0;
		sink_stall_en = 1'b0;
		quiet_tail = 1'b0;
		items_sent = 0;
		chk = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A restart right after reset carries a byte that must be ignored.
		send_item(OP_RESTART, 8'hFF);
		program_registers(8'hA5, 16'd4, 1'b1);
		// A byte that is not the header leaves the receiver hunting.
		send_item(OP_BYTE, 8'h00);
		// Zero length goes straight from the length bytes to the checksum byte.
		send_frame(0, 1'b0);
		// A completed frame holds its status against further bytes until a restart.
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_RESTART, 8'h00);
		// One above the maximum gives a length error that stays while the next frame
		// is read, and that frame then fails its checksum.
		send_prefix(5, sum);
		send_frame(1, 1'b1);
		send_item(OP_RESTART, BYTE_W'($urandom));
		// A payload exactly as long as the maximum is accepted.
		send_frame(4, 1'b0);

		// Random part, through several register settings with the extremes among them.
		program_registers(8'h00, 16'd0, 1'b1);
		run_random(210);
		program_registers(8'hFF, 16'hFFFF, 1'b0);
		run_random(210);
		repeat (3) begin
			program_registers(BYTE_W'($urandom), LEN_W'($urandom_range(1, 12)),
				1'($urandom_range(0, 1)));
			run_random(210);
		end
		// The last stretch runs at full rate on both sides.
		quiet_tail = 1'b1;
		src_idle_en = 1'b0;
		sink_stall_en = 1'b0;
		program_registers(BYTE_W'($urandom), LEN_W'($urandom_range(2, 8)), 1'b1);
		run_random(180);

		wait_idle();
		if (chk.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Far beyond the slowest correct run; a hang ends here.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
